// ----- design/sorted_merge_dedup_latest_unit_macros.svh -----
// Assertion macros for the merge/dedup unit checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef SORTED_MERGE_DEDUP_LATEST_UNIT_MACROS_SVH
`define SORTED_MERGE_DEDUP_LATEST_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its trigger
`define SMDL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smdl check failed: same-cycle property");

// Check a consequence in the cycle after its trigger
`define SMDL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smdl check failed: next-cycle property");

`endif

// ----- design/smdl_pkg.sv -----
// Shared types, constants and key compare functions for the merge/dedup unit.
// No dependencies; every other file but the macro header refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package smdl_pkg;

	localparam int unsigned COL_BYTES = 8;
	localparam int unsigned COL_W     = COL_BYTES * 8;
	localparam int unsigned ID_W      = 32;
	localparam int unsigned TAG_W     = 32;
	localparam int unsigned DUP_W     = 32;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned WANT_W    = 2;
	localparam int unsigned QDEPTH    = 4;
	localparam int unsigned QPTR_W    = $clog2(QDEPTH);
	localparam int unsigned QCNT_W    = QPTR_W + 1;
	localparam int unsigned APB_AW    = 2;
	localparam int unsigned APB_DW    = 32;

	typedef logic [MODE_W-1:0] mode_t;

	// Key mode codes; the unused code compares the id only
	localparam mode_t MODE_ID_ONLY = MODE_W'(0);
	localparam mode_t MODE_ID_A    = MODE_W'(1);
	localparam mode_t MODE_ID_A_B  = MODE_W'(2);

	// Item kind codes
	localparam logic KIND_REC = 1'b0;
	localparam logic KIND_END = 1'b1;

	// Stream request codes
	localparam logic [WANT_W-1:0] WANT_S0   = WANT_W'(0);
	localparam logic [WANT_W-1:0] WANT_S1   = WANT_W'(1);
	localparam logic [WANT_W-1:0] WANT_NONE = WANT_W'(2);

	// Register index of pk_mode
	localparam int unsigned REG_PK_MODE = 0;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_COMMIT,
		ACT_FLUSH
	} act_t;

	typedef struct packed {
		logic signed [ID_W-1:0] id;
		logic [COL_W-1:0]       a;
		logic [COL_W-1:0]       b;
		logic [COL_W-1:0]       upd;
		logic [TAG_W-1:0]       tag;
	} rec_t;

	// One classified request handed from front to back
	typedef struct packed {
		act_t                act;
		rec_t                rec;
		logic [WANT_W-1:0]   want;
		logic                finished;
	} q_entry_t;

	// Strict less-than on the key selected by mode
	function automatic logic key_lt(mode_t mode, rec_t x, rec_t y);
		logic lt;
		if (x.id != y.id) begin
			lt = ($signed(x.id) < $signed(y.id));
		end else begin
			case (mode)
				MODE_ID_A: begin
					lt = (x.a < y.a);
				end
				MODE_ID_A_B: begin
					lt = (x.a != y.a) ? (x.a < y.a) : (x.b < y.b);
				end
				default: begin
					lt = 1'b0;
				end
			endcase
		end
		return lt;
	endfunction

	// Key equality on the key selected by mode
	function automatic logic key_eq(mode_t mode, rec_t x, rec_t y);
		logic eq;
		case (mode)
			MODE_ID_A: begin
				eq = (x.id == y.id) && (x.a == y.a);
			end
			MODE_ID_A_B: begin
				eq = (x.id == y.id) && (x.a == y.a) && (x.b == y.b);
			end
			default: begin
				eq = (x.id == y.id);
			end
		endcase
		return eq;
	endfunction

endpackage

`default_nettype wire

// ----- design/smdl_in_if.sv -----
// Input channel: one record or end mark per request, valid/ready handshake.
// Depends on smdl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface smdl_in_if;
	logic                              valid;
	logic                              ready;
	logic                              kind;
	logic                              stream_sel;
	logic signed [smdl_pkg::ID_W-1:0]  rec_id;
	logic [smdl_pkg::COL_W-1:0]        col_a;
	logic [smdl_pkg::COL_W-1:0]        col_b;
	logic [smdl_pkg::COL_W-1:0]        upd_stamp;
	logic [smdl_pkg::TAG_W-1:0]        rec_tag;

	modport source (
		output valid, kind, stream_sel, rec_id, col_a, col_b, upd_stamp, rec_tag,
		input  ready
	);
	modport sink (
		input  valid, kind, stream_sel, rec_id, col_a, col_b, upd_stamp, rec_tag,
		output ready
	);
endinterface

`default_nettype wire

// ----- design/smdl_out_if.sv -----
// Output channel: one result request per accepted input, valid/ready handshake.
// Depends on smdl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface smdl_out_if;
	logic                              valid;
	logic                              ready;
	logic                              has_record;
	logic signed [smdl_pkg::ID_W-1:0]  out_id;
	logic [smdl_pkg::TAG_W-1:0]        out_tag;
	logic [smdl_pkg::WANT_W-1:0]       want_source;
	logic                              finished;
	logic [smdl_pkg::DUP_W-1:0]        dup_total;

	modport source (
		output valid, has_record, out_id, out_tag, want_source, finished, dup_total,
		input  ready
	);
	modport sink (
		input  valid, has_record, out_id, out_tag, want_source, finished, dup_total,
		output ready
	);
endinterface

`default_nettype wire

// ----- design/smdl_front.sv -----
// Front end: accepts items, keeps the two stream heads, picks the next commit.
// Depends on smdl_pkg and smdl_in_if; feeds smdl_fifo.
`timescale 1ns / 1ps
`default_nettype none

module smdl_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire smdl_pkg::mode_t      pk_mode,
	smdl_in_if.sink                   in_ch,
	input  wire logic                 q_full,
	output logic                      q_push,
	output smdl_pkg::q_entry_t        q_data
);

	logic [1:0]           head_valid_q;
	logic [1:0]           stream_ended_q;
	logic                 done_q;
	smdl_pkg::rec_t       head_q [2];

	logic [1:0]           head_valid_n;
	logic [1:0]           stream_ended_n;
	logic                 done_n;
	smdl_pkg::rec_t       head_n [2];
	smdl_pkg::rec_t       in_rec;
	logic                 accept;
	logic                 sel;
	logic                 both_ready;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign q_push      = accept;

	// Pack the incoming record
	always_comb begin
		in_rec.id  = in_ch.rec_id;
		in_rec.a   = in_ch.col_a;
		in_rec.b   = in_ch.col_b;
		in_rec.upd = in_ch.upd_stamp;
		in_rec.tag = in_ch.rec_tag;
	end

	// Update heads, classify the step and compute the next request
	always_comb begin
		head_valid_n   = head_valid_q;
		stream_ended_n = stream_ended_q;
		done_n         = done_q;
		head_n[0]      = head_q[0];
		head_n[1]      = head_q[1];
		sel            = 1'b0;

		if (in_ch.kind == smdl_pkg::KIND_REC) begin
			if (!stream_ended_q[in_ch.stream_sel] && !head_valid_q[in_ch.stream_sel]) begin
				head_valid_n[in_ch.stream_sel] = 1'b1;
				head_n[in_ch.stream_sel]       = in_rec;
			end
		end else begin
			stream_ended_n[in_ch.stream_sel] = 1'b1;
		end

		both_ready = (head_valid_n[0] || stream_ended_n[0]) &&
		             (head_valid_n[1] || stream_ended_n[1]);

		q_data.act      = smdl_pkg::ACT_NONE;
		q_data.rec      = head_n[0];

		if (!done_q && both_ready) begin
			if (head_valid_n[0] && head_valid_n[1]) begin
				// Ties go to stream 1
				sel         = !smdl_pkg::key_lt(pk_mode, head_n[0], head_n[1]);
				q_data.act  = smdl_pkg::ACT_COMMIT;
			end else if (head_valid_n[0]) begin
				sel         = 1'b0;
				q_data.act  = smdl_pkg::ACT_COMMIT;
			end else if (head_valid_n[1]) begin
				sel         = 1'b1;
				q_data.act  = smdl_pkg::ACT_COMMIT;
			end else begin
				q_data.act  = smdl_pkg::ACT_FLUSH;
				done_n      = 1'b1;
			end
		end

		if (q_data.act == smdl_pkg::ACT_COMMIT) begin
			q_data.rec        = head_n[sel];
			head_valid_n[sel] = 1'b0;
		end

		if (!head_valid_n[0] && !stream_ended_n[0]) begin
			q_data.want = smdl_pkg::WANT_S0;
		end else if (!head_valid_n[1] && !stream_ended_n[1]) begin
			q_data.want = smdl_pkg::WANT_S1;
		end else begin
			q_data.want = smdl_pkg::WANT_NONE;
		end
		q_data.finished = done_n;
	end

	// Advance control state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q   <= '0;
			stream_ended_q <= '0;
			done_q         <= 1'b0;
		end else if (accept) begin
			head_valid_q   <= head_valid_n;
			stream_ended_q <= stream_ended_n;
			done_q         <= done_n;
		end
	end

	// Hold head payloads
	always_ff @(posedge clk) begin
		if (accept) begin
			head_q[0] <= head_n[0];
			head_q[1] <= head_n[1];
		end
	end

endmodule

`default_nettype wire

// ----- design/smdl_fifo.sv -----
// Short request queue between front and back ends.
// Depends on smdl_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module smdl_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire smdl_pkg::q_entry_t   push_data,
	output logic                      full,
	input  wire logic                 pop,
	output smdl_pkg::q_entry_t        pop_data,
	output logic                      empty
);

	smdl_pkg::q_entry_t                 mem_q [smdl_pkg::QDEPTH];
	logic [smdl_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [smdl_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [smdl_pkg::QCNT_W-1:0]        count_q;
	logic                               do_push;
	logic                               do_pop;

	assign full     = (count_q == smdl_pkg::QCNT_W'(smdl_pkg::QDEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + smdl_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + smdl_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + smdl_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - smdl_pkg::QCNT_W'(1);
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- design/smdl_back.sv -----
// Back end: collapses equal keys into the held record, counts duplicates, emits.
// Depends on smdl_pkg and smdl_out_if; drains smdl_fifo.
`timescale 1ns / 1ps
`default_nettype none

module smdl_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire smdl_pkg::mode_t      pk_mode,
	input  wire logic                 q_empty,
	input  wire smdl_pkg::q_entry_t   q_data,
	output logic                      q_pop,
	smdl_out_if.source                out_ch
);

	logic                               held_valid_q;
	smdl_pkg::rec_t                     held_q;
	logic [smdl_pkg::DUP_W-1:0]         dup_q;

	logic                               out_valid_q;
	logic                               out_has_q;
	logic signed [smdl_pkg::ID_W-1:0]   out_id_q;
	logic [smdl_pkg::TAG_W-1:0]         out_tag_q;
	logic [smdl_pkg::WANT_W-1:0]        out_want_q;
	logic                               out_fin_q;
	logic [smdl_pkg::DUP_W-1:0]         out_dup_q;

	logic                               held_valid_n;
	smdl_pkg::rec_t                     held_n;
	logic [smdl_pkg::DUP_W-1:0]         dup_n;
	logic                               emit;
	logic                               slot_free;

	assign slot_free = !out_valid_q || out_ch.ready;
	assign q_pop     = !q_empty && slot_free;

	// Carry out one request against the held record
	always_comb begin
		held_valid_n = held_valid_q;
		held_n       = held_q;
		dup_n        = dup_q;
		emit         = 1'b0;
		case (q_data.act)
			smdl_pkg::ACT_COMMIT: begin
				if (held_valid_q && smdl_pkg::key_eq(pk_mode, held_q, q_data.rec)) begin
					if (dup_q != '1) begin
						dup_n = dup_q + smdl_pkg::DUP_W'(1);
					end
					// Keep the later update; the earlier record stays on a tie
					if (held_q.upd < q_data.rec.upd) begin
						held_n = q_data.rec;
					end
				end else begin
					emit         = held_valid_q;
					held_n       = q_data.rec;
					held_valid_n = 1'b1;
				end
			end
			smdl_pkg::ACT_FLUSH: begin
				emit         = held_valid_q;
				held_valid_n = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Advance held state and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			dup_q        <= '0;
			out_valid_q  <= 1'b0;
			out_has_q    <= 1'b0;
			out_id_q     <= '0;
			out_tag_q    <= '0;
			out_want_q   <= smdl_pkg::WANT_S0;
			out_fin_q    <= 1'b0;
			out_dup_q    <= '0;
		end else begin
			if (q_pop) begin
				held_valid_q <= held_valid_n;
				dup_q        <= dup_n;
				out_valid_q  <= 1'b1;
				out_has_q    <= emit;
				out_id_q     <= emit ? held_q.id : '0;
				out_tag_q    <= emit ? held_q.tag : '0;
				out_want_q   <= q_data.want;
				out_fin_q    <= q_data.finished;
				out_dup_q    <= dup_n;
			end else if (out_ch.ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	// Hold the record payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			held_q <= held_n;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.has_record  = out_has_q;
	assign out_ch.out_id      = out_id_q;
	assign out_ch.out_tag     = out_tag_q;
	assign out_ch.want_source = out_want_q;
	assign out_ch.finished    = out_fin_q;
	assign out_ch.dup_total   = out_dup_q;

endmodule

`default_nettype wire

// ----- design/sorted_merge_dedup_latest_unit.sv -----
// Top level of the two-way sorted merge with duplicate elimination.
// Depends on smdl_pkg, smdl_in_if, smdl_out_if, smdl_front, smdl_fifo, smdl_back.
//
//   port      | direction | carries
//   ----------+-----------+-------------------------------------------------
//   in_ch     | sink      | record or end mark for stream 0 or 1
//   out_ch    | source    | one result per item: emitted record, next stream,
//             |           | finished flag, duplicate total
//   apb       | slave     | pk_mode at byte address 0
//
// One item per cycle sustained unless out_ch stalls; each item goes through the
// queue and the output register. The front compares both heads in the accept
// cycle; the back compares the committed record with the held one in the cycle
// it leaves the 4-entry queue. in_ch.ready drops only when that queue is full,
// so a stalled output holds five pending results (four queued, one in the output
// register) before the input stalls. Reset is asynchronous; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sorted_merge_dedup_latest_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [smdl_pkg::APB_AW-1:0]   paddr,
	input  wire logic [smdl_pkg::APB_DW-1:0]   pwdata,
	output logic      [smdl_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	smdl_in_if.sink                            in_ch,
	smdl_out_if.source                         out_ch
);

	smdl_pkg::mode_t       pk_mode_q;
	logic                  cfg_wr;
	logic                  q_full;
	logic                  q_empty;
	logic                  q_push;
	logic                  q_pop;
	smdl_pkg::q_entry_t    q_in;
	smdl_pkg::q_entry_t    q_out;

	// Decode the register word; one register fills the address space
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
	                (paddr == smdl_pkg::APB_AW'(smdl_pkg::REG_PK_MODE * 4));
	assign prdata = smdl_pkg::APB_DW'(pk_mode_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_mode_q <= smdl_pkg::MODE_ID_ONLY;
		end else if (cfg_wr) begin
			pk_mode_q <= pwdata[smdl_pkg::MODE_W-1:0];
		end
	end

	smdl_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.pk_mode (pk_mode_q),
		.in_ch   (in_ch),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_in)
	);

	smdl_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	smdl_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.pk_mode (pk_mode_q),
		.q_empty (q_empty),
		.q_data  (q_out),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

`default_nettype wire

// ----- design/smdl_checker.sv -----
// Port-level checks on the result channel of the merge/dedup unit, and its bind.
// Depends on smdl_pkg and sorted_merge_dedup_latest_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_merge_dedup_latest_unit_macros.svh"

module smdl_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                out_valid,
	input  wire logic                                out_ready,
	input  wire logic                                has_record,
	input  wire logic signed [smdl_pkg::ID_W-1:0]    out_id,
	input  wire logic [smdl_pkg::TAG_W-1:0]          out_tag,
	input  wire logic [smdl_pkg::WANT_W-1:0]         want_source,
	input  wire logic                                finished,
	input  wire logic [smdl_pkg::DUP_W-1:0]          dup_total
);

	// A stalled result keeps its record
	`SMDL_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_id) && $stable(out_tag) && $stable(has_record))

	// Once finished, it stays finished
	`SMDL_ASSERT_NEXT(a_fin_sticky, finished, finished)

	// The duplicate total never goes down
	`SMDL_ASSERT_NEXT(a_dup_mono, 1'b1, dup_total >= $past(dup_total))

	// A result without a record carries zeros
	`SMDL_ASSERT_NOW(a_empty_zero, out_valid && !has_record, out_id == '0 && out_tag == '0)

	// After the final flush no stream is requested
	`SMDL_ASSERT_NOW(a_fin_idle, out_valid && finished, want_source == smdl_pkg::WANT_NONE)

endmodule

bind sorted_merge_dedup_latest_unit smdl_checker u_smdl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.has_record  (out_ch.has_record),
	.out_id      (out_ch.out_id),
	.out_tag     (out_ch.out_tag),
	.want_source (out_ch.want_source),
	.finished    (out_ch.finished),
	.dup_total   (out_ch.dup_total)
);

`default_nettype wire
